// ===== rtl/hall_sensor_angle_speed_estimator_core_macros.svh =====
// Assertion macros shared by the estimator RTL
`ifndef HALL_SENSOR_ANGLE_SPEED_ESTIMATOR_CORE_MACROS_SVH
`define HALL_SENSOR_ANGLE_SPEED_ESTIMATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HSE_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HSE_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSE_ASSERT(label, clk, rstn, prop, msg)
`define HSE_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/hse_pkg.sv =====
package hse_pkg;
    localparam int TW = 32;
    localparam int AW = 24;
    localparam logic [AW-1:0] HALF_TURN = 24'h800000;
    localparam logic [AW-1:0] SIXTH     = 24'd2796202;
    localparam logic [AW-1:0] TWELFTH   = 24'd1398101;
    localparam logic [AW-1:0] JUMP_LIMIT = 24'd2842806;
    localparam logic [9:0]   TICKS_PER_SECOND = 10'd1000;

    localparam logic [1:0] REQ_EDGE   = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_UPDATE = 2'd2;

    localparam logic [2:0] REG_USER_DIR  = 3'd0;
    localparam logic [2:0] REG_ANGLE_MODE = 3'd1;
    localparam logic [2:0] REG_OFFSET    = 3'd2;
    localparam logic [2:0] REG_SCALE     = 3'd3;
    localparam logic [2:0] REG_TIMEOUT   = 3'd4;
    localparam logic [2:0] REG_SPEED_MIN = 3'd5;
    localparam logic [2:0] REG_WRONG_LIM = 3'd6;

    // controller -> datapath commands
    typedef struct packed {
        logic load;       // latch input beat
        logic do_edge;
        logic do_tick;
        logic upd_pre;    // speed divider start setup
        logic div_start;
        logic div_sel;    // 0 speed divide, 1 angle divide
        logic upd_speed;  // take speed quotient
        logic upd_angle;  // take angle quotient or midpoint, finish
    } hse_cmd_t;

    typedef struct packed {
        logic div_done;
        logic speed_div_needed;
        logic angle_div_needed;
    } hse_stat_t;

    function automatic logic [AW-1:0] sector_of_code(input logic [2:0] code,
                                                     input logic [AW-1:0] keep);
        case (code)
            3'd5: sector_of_code = '0;
            3'd4: sector_of_code = 24'd2796202;
            3'd6: sector_of_code = 24'd5592405;
            3'd2: sector_of_code = 24'd8388608;
            3'd3: sector_of_code = 24'd11184810;
            3'd1: sector_of_code = 24'd13981013;
            default: sector_of_code = keep;
        endcase
    endfunction
endpackage

// ===== rtl/hse_divider.sv =====
// Restoring divider, 56-bit dividend / 32-bit divisor, one bit per cycle
module hse_divider import hse_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [55:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [55:0] quotient
);
    logic [55:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    assign trial = {r_reg[31:0], q_reg[55]};

    always_comb begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        if (start) begin
            q_next = dividend; r_next = '0; d_next = divisor;
            cnt_next = 6'd56; busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[54:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[54:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next; cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quotient = q_reg;
endmodule

// ===== rtl/hse_datapath.sv =====
// Estimator state and arithmetic
module hse_datapath import hse_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  hse_cmd_t    cmd,
    output hse_stat_t   stat,
    input  logic [1:0]  in_channel,
    input  logic [31:0] in_time,
    input  logic [2:0]  in_levels,
    input  logic        user_direction,
    input  logic        angle_mode,
    input  logic [23:0] angle_offset,
    input  logic [31:0] speed_scale,
    input  logic [15:0] timeout_ms,
    input  logic [30:0] speed_min,
    input  logic [15:0] wrong_code_limit,
    output logic [79:0] res_data
);
    logic [1:0]  ch_reg;
    logic [31:0] t_reg;
    logic [2:0]  lv_reg;
    logic [23:0] sector_reg, prev_sector_reg, angle_reg;
    logic [1:0]  last_ch_reg, seen_reg;
    logic        dir_reg, dir_prev_reg, timed_out_reg, above_reg, fault_reg;
    logic [15:0] ms_reg, wrong_total_reg, wrong_sec_reg;
    logic [9:0]  sec_ticks_reg;
    logic [31:0] sper_reg, cper_reg, last_t_reg, speed_reg;
    logic [31:0] ch_time_reg [3];

    logic        div_done;
    logic [55:0] div_q, div_a;
    logic [31:0] div_b;

    // edge and update path arithmetic
    logic [2:0]  code;
    logic [23:0] new_sec, x, diff;
    logic        wrong;
    logic [31:0] dt;
    logic [34:0] sp;
    logic [1:0]  ch_p1, ch_p2;
    logic [31:0] mag, spd_cur, dt_upd;
    logic [23:0] frac, frac_div;
    logic        neg, ang_div;

    always_comb begin
        code = user_direction ? {lv_reg[0], lv_reg[1], lv_reg[2]} : lv_reg;
        new_sec = sector_of_code(code, sector_reg);
        x = new_sec - prev_sector_reg + HALF_TURN;
        diff = (x >= HALF_TURN) ? (x - HALF_TURN) : (HALF_TURN - x);
        wrong = diff > JUMP_LIMIT;
        dt = t_reg - last_t_reg;
        sp = {3'b0, dt} * 35'd6;
        ch_p1 = (ch_reg == 2'd2) ? 2'd0 : ch_reg + 2'd1;
        ch_p2 = (ch_reg == 2'd0) ? 2'd2 : ch_reg - 2'd1;
        dt_upd = t_reg - last_t_reg;
        // speed quotient saturated and signed
        mag = (div_q > 56'h7FFFFFFF) ? 32'h7FFFFFFF : div_q[31:0];
        neg = dir_reg ^ user_direction;
        spd_cur = neg ? (32'd0 - mag) : mag;
        frac_div = (div_q >= {32'd0, SIXTH}) ? SIXTH : div_q[23:0];
        ang_div = (speed_reg != 32'd0) && angle_mode && (sper_reg != 32'd0);
        frac = ang_div ? frac_div : TWELFTH;
        if (dir_reg) frac = SIXTH - frac;
        if (user_direction) frac = SIXTH - frac;
        div_a = cmd.div_sel ? {dt_upd, 24'd0} : {speed_scale, 24'd0};
        div_b = cmd.div_sel ? sper_reg : cper_reg;
    end

    assign stat.div_done = div_done;
    assign stat.speed_div_needed = (cper_reg != 32'd0) && !timed_out_reg
                                   && !(ms_reg > timeout_ms);
    assign stat.angle_div_needed = ang_div;

    hse_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    // payload capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ch_reg <= in_channel; t_reg <= in_time; lv_reg <= in_levels;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_reg <= '0; prev_sector_reg <= '0; angle_reg <= '0;
            last_ch_reg <= '0; seen_reg <= '0; dir_reg <= 1'b0;
            dir_prev_reg <= 1'b0; timed_out_reg <= 1'b0; above_reg <= 1'b0;
            fault_reg <= 1'b0; ms_reg <= '0; wrong_total_reg <= '0;
            wrong_sec_reg <= '0; sec_ticks_reg <= '0; sper_reg <= '0;
            cper_reg <= '0; last_t_reg <= '0; speed_reg <= '0;
            ch_time_reg[0] <= '0; ch_time_reg[1] <= '0; ch_time_reg[2] <= '0;
        end else begin
            if (cmd.do_edge && ch_reg != 2'd3) begin
                sector_reg <= new_sec;
                prev_sector_reg <= new_sec;
                if (wrong) begin
                    if (wrong_total_reg != 16'hFFFF) wrong_total_reg <= wrong_total_reg + 16'd1;
                    if (wrong_sec_reg != 16'hFFFF) wrong_sec_reg <= wrong_sec_reg + 16'd1;
                end
                if (seen_reg >= 2'd2) begin
                    timed_out_reg <= ms_reg > timeout_ms;
                    if (ms_reg > timeout_ms) speed_reg <= '0;
                    if (last_ch_reg == ch_p2) begin
                        dir_reg <= 1'b0; dir_prev_reg <= 1'b0;
                    end else if (last_ch_reg == ch_p1) begin
                        dir_reg <= 1'b1; dir_prev_reg <= 1'b1;
                    end else begin
                        dir_reg <= ~dir_prev_reg; dir_prev_reg <= ~dir_prev_reg;
                    end
                    sper_reg <= (sp[34:32] != 3'd0) ? 32'hFFFFFFFF : sp[31:0];
                    cper_reg <= t_reg - ch_time_reg[ch_reg];
                end else begin
                    sper_reg <= '0; cper_reg <= '0;
                end
                last_t_reg <= t_reg;
                ch_time_reg[ch_reg] <= t_reg;
                if (seen_reg != 2'd3) seen_reg <= seen_reg + 2'd1;
                ms_reg <= '0;
                last_ch_reg <= ch_reg;
            end
            if (cmd.do_tick) begin
                if (ms_reg != 16'hFFFF) ms_reg <= ms_reg + 16'd1;
                if (sec_ticks_reg + 10'd1 > TICKS_PER_SECOND) begin
                    fault_reg <= wrong_sec_reg > wrong_code_limit;
                    wrong_sec_reg <= '0;
                    sec_ticks_reg <= '0;
                end else begin
                    sec_ticks_reg <= sec_ticks_reg + 10'd1;
                end
            end
            // update: speed first (zero unless divided), then timeout
            if (cmd.upd_pre) begin
                speed_reg <= '0;
                if (ms_reg > timeout_ms) timed_out_reg <= 1'b1;
                above_reg <= 1'b0;
            end
            if (cmd.upd_speed) begin
                speed_reg <= spd_cur;
                above_reg <= {1'b0, mag[30:0]} > {1'b0, speed_min} || mag[31];
            end
            if (cmd.upd_angle)
                angle_reg <= sector_reg + frac + angle_offset;
        end
    end

    assign res_data = {4'd0, wrong_total_reg, fault_reg, above_reg, timed_out_reg,
                       dir_reg, speed_reg, angle_reg};

    `include "hall_sensor_angle_speed_estimator_core_macros.svh"
    `HSE_ASSERT(a_seen_sat, aclk, aresetn, (seen_reg == 2'd3) |=> (seen_reg == 2'd3), "seen")
    `HSE_ASSERT(a_edge_clr_ms, aclk, aresetn, (cmd.do_edge && ch_reg != 2'd3) |=> (ms_reg == 16'd0), "ms")
    `HSE_ASSERT(a_sec_range, aclk, aresetn, $past(sec_ticks_reg) <= TICKS_PER_SECOND |-> sec_ticks_reg <= TICKS_PER_SECOND, "sec")
endmodule

// ===== rtl/hse_ctrl.sv =====
// Sequencer: accept, run edge/tick/update, present result
module hse_ctrl import hse_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  req,
    output logic        m_tvalid,
    input  logic        m_tready,
    output hse_cmd_t    cmd,
    input  hse_stat_t   stat
);
    localparam logic [2:0] S_IDLE = 3'd0, S_EXEC = 3'd1, S_SDIV = 3'd2,
                           S_ASTART = 3'd3, S_ADIV = 3'd4, S_OUT = 3'd5;
    logic [2:0] state_reg, state_next;
    logic [1:0] req_reg;
    logic       mv_reg, mv_next;

    assign s_tready = (state_reg == S_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) req_reg <= req;
        if (!aresetn) begin
            state_reg <= S_IDLE; mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next; mv_reg <= mv_next;
        end
    end

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        mv_next = mv_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.load = 1'b1; state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.do_edge = (req_reg == REQ_EDGE);
                cmd.do_tick = (req_reg == REQ_TICK);
                if (req_reg == REQ_UPDATE) begin
                    cmd.upd_pre = 1'b1;
                    if (stat.speed_div_needed) begin
                        cmd.div_start = 1'b1; state_next = S_SDIV;
                    end else state_next = S_ASTART;
                end else state_next = S_OUT;
            end
            S_SDIV: if (stat.div_done) begin
                cmd.upd_speed = 1'b1; state_next = S_ASTART;
            end
            S_ASTART: begin
                cmd.div_sel = 1'b1;
                if (stat.angle_div_needed) begin
                    cmd.div_start = 1'b1; state_next = S_ADIV;
                end else begin
                    cmd.upd_angle = 1'b1; state_next = S_OUT;
                end
            end
            S_ADIV: begin
                cmd.div_sel = 1'b1;
                if (stat.div_done) begin
                    cmd.upd_angle = 1'b1; state_next = S_OUT;
                end
            end
            S_OUT: begin
                mv_next = 1'b1; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    `include "hall_sensor_angle_speed_estimator_core_macros.svh"
    `HSE_ASSERT(a_no_accept_busy, aclk, aresetn, (state_reg != S_IDLE) |-> !s_tready, "busy accept")
    `HSE_ASSERT(a_out_after, aclk, aresetn, (state_reg == S_OUT) |=> m_tvalid, "no result")
    `HSE_ASSERT_RST(a_rst, aclk, !aresetn |=> (state_reg == S_IDLE && !m_tvalid), "reset")
endmodule

// ===== rtl/hall_sensor_angle_speed_estimator_core.sv =====
// Hall sensor angle/speed estimator. Beats carry an edge capture, a 1 ms tick or an
// update request, the kind of beat in s_tuser; each beat yields one result beat with
// the state after it. An edge, a tick or a reserved beat passes through the execute and
// output states before its result is presented; an update runs up to two 56-step passes
// of the bit-serial divider shared by the speed and in-sector angle divisions. One beat
// is processed at a time; the next is taken in the cycle after the result has been
// accepted.
module hall_sensor_angle_speed_estimator_core import hse_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    input  logic [39:0] s_tdata,   // channel[1:0], timestamp[33:2], hall_levels[36:34]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // angle[23:0], speed[55:24], direction[56], zero_speed[57],
                                   // above_min_speed[58], sensor_fault[59], wrong_code_count[75:60]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    logic        udir_reg, amode_reg;
    logic [23:0] offset_reg;
    logic [31:0] scale_reg;
    logic [15:0] timeout_reg, wlim_reg;
    logic [30:0] smin_reg;
    hse_cmd_t    cmd;
    hse_stat_t   stat;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            udir_reg <= 1'b0; amode_reg <= 1'b1; offset_reg <= '0; scale_reg <= '0;
            timeout_reg <= 16'd1000; smin_reg <= '0; wlim_reg <= 16'd10;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_USER_DIR:   udir_reg <= cfg_wdata[0];
                REG_ANGLE_MODE: amode_reg <= cfg_wdata[0];
                REG_OFFSET:     offset_reg <= cfg_wdata[23:0];
                REG_SCALE:      scale_reg <= cfg_wdata;
                REG_TIMEOUT:    timeout_reg <= cfg_wdata[15:0];
                REG_SPEED_MIN:  smin_reg <= cfg_wdata[30:0];
                REG_WRONG_LIM:  wlim_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    hse_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .req(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cmd(cmd), .stat(stat)
    );

    hse_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_channel(s_tdata[1:0]), .in_time(s_tdata[33:2]),
        .in_levels(s_tdata[36:34]), .user_direction(udir_reg), .angle_mode(amode_reg),
        .angle_offset(offset_reg), .speed_scale(scale_reg), .timeout_ms(timeout_reg),
        .speed_min(smin_reg), .wrong_code_limit(wlim_reg), .res_data(m_tdata)
    );
endmodule

// ===== bench/tb_hall_sensor_angle_speed_estimator_core.sv =====
module tb_hall_sensor_angle_speed_estimator_core;
    timeunit 1ns;
    timeprecision 1ps;
    import hse_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [23:0] ANG_ONE = 24'hFFFFFF;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    typedef struct packed {
        logic [23:0] angle;
        logic [31:0] speed;
        logic        direction;
        logic        zero_speed;
        logic        above_min;
        logic        fault;
        logic [15:0] wrong_count;
    } hall_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser = '0;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    hall_sensor_angle_speed_estimator_core dut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    // estimator copy: configuration
    logic        c_user_dir, c_angle_mode;
    logic [23:0] c_offset;
    logic [31:0] c_scale;
    logic [15:0] c_timeout, c_wrong_lim;
    logic [30:0] c_speed_min;
    // estimator copy: state
    logic [23:0] e_sector, e_prev_sector, e_angle;
    logic [1:0]  e_last_ch, e_edges;
    logic        e_dir, e_dir_prev, e_timed_out, e_fault, e_above;
    logic [15:0] e_ms, e_wrong_total, e_wrong_sec;
    logic [9:0]  e_sec_ticks;
    logic [31:0] e_sector_period, e_channel_period, e_last_time, e_speed;
    logic [31:0] e_ch_time [3];

    hall_result_t expected_results[$];
    int  n_fail = 0;
    int  sender_idle_pct = 0;
    int  receiver_stall_pct = 0;
    bit  long_holdoff = 0;
    longint quiet_cycles = 0;

    task automatic estimator_reset();
        c_user_dir = 0; c_angle_mode = 1; c_offset = 0; c_scale = 0;
        c_timeout = 1000; c_speed_min = 0; c_wrong_lim = 10;
        e_sector = 0; e_prev_sector = 0; e_angle = 0; e_last_ch = 0; e_edges = 0;
        e_dir = 0; e_dir_prev = 0; e_timed_out = 0; e_fault = 0; e_above = 0;
        e_ms = 0; e_wrong_total = 0; e_wrong_sec = 0; e_sec_ticks = 0;
        e_sector_period = 0; e_channel_period = 0; e_last_time = 0; e_speed = 0;
        for (int i = 0; i < 3; i++) e_ch_time[i] = 0;
    endtask

    function automatic logic [23:0] hall_sector(logic [2:0] code, logic [23:0] keep);
        case (code)
            3'd5: return 24'd0;
            3'd4: return 24'd2796202;
            3'd6: return 24'd5592405;
            3'd2: return 24'd8388608;
            3'd3: return 24'd11184810;
            3'd1: return 24'd13981013;
            default: return keep;
        endcase
    endfunction

    task automatic estimate_edge(logic [1:0] ch, logic [31:0] t, logic [2:0] lv);
        logic [2:0] code;
        logic [23:0] x, diff;
        logic [31:0] d;
        logic [63:0] sp;
        if (ch > 2) return;
        code = c_user_dir ? {lv[0], lv[1], lv[2]} : lv;
        e_sector = hall_sector(code, e_sector);
        x = e_sector - e_prev_sector + HALF_TURN;
        diff = (x >= HALF_TURN) ? x - HALF_TURN : HALF_TURN - x;
        e_prev_sector = e_sector;
        if (diff > JUMP_LIMIT) begin
            if (e_wrong_total != 16'hFFFF) e_wrong_total++;
            if (e_wrong_sec != 16'hFFFF) e_wrong_sec++;
        end
        if (e_edges >= 2) begin
            e_timed_out = e_ms > c_timeout;
            if (e_timed_out) e_speed = 0;
            if (e_last_ch == (ch + 2) % 3) e_dir = 0;
            else if (e_last_ch == (ch + 1) % 3) e_dir = 1;
            else e_dir = ~e_dir_prev;
            e_dir_prev = e_dir;
            d = t - e_last_time;
            sp = {32'd0, d} * 64'd6;
            e_sector_period = (sp > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sp[31:0];
            e_channel_period = t - e_ch_time[ch];
        end else begin
            e_sector_period = 0;
            e_channel_period = 0;
        end
        e_last_time = t;
        e_ch_time[ch] = t;
        if (e_edges != 3) e_edges++;
        e_ms = 0;
        e_last_ch = ch;
    endtask

    task automatic estimate_update(logic [31:0] t);
        logic [63:0] q;
        logic [31:0] mag;
        logic [23:0] frac;
        e_speed = 0;
        if (e_channel_period != 0 && !e_timed_out) begin
            q = {c_scale, 24'd0} / e_channel_period;
            mag = (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
            e_speed = (e_dir ^ c_user_dir) ? -mag : mag;
        end
        if (e_ms > c_timeout) begin
            e_speed = 0;
            e_timed_out = 1;
        end
        mag = e_speed[31] ? -e_speed : e_speed;
        e_above = mag > {1'b0, c_speed_min};
        if (e_speed == 0 || !c_angle_mode || e_sector_period == 0) begin
            frac = TWELFTH;
        end else begin
            q = {t - e_last_time, 24'd0} / e_sector_period;
            frac = (q >= SIXTH) ? SIXTH : q[23:0];
        end
        if (e_dir) frac = SIXTH - frac;
        if (c_user_dir) frac = SIXTH - frac;
        e_angle = (e_sector + frac + c_offset) & ANG_ONE;
    endtask

    function automatic hall_result_t estimator_result();
        return '{e_angle, e_speed, e_dir, e_timed_out, e_above, e_fault, e_wrong_total};
    endfunction

    // send one beat, predict its result once accepted; valid stays up until an idle
    // cycle, a register write or a drain takes it down
    task automatic send_beat(logic [1:0] req, logic [1:0] ch, logic [31:0] t, logic [2:0] lv);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {3'b0, lv, t, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (req)
            REQ_EDGE: estimate_edge(ch, t, lv);
            REQ_TICK: begin
                if (e_ms != 16'hFFFF) e_ms++;
                e_sec_ticks++;
                if (e_sec_ticks > TICKS_PER_SECOND) begin
                    e_fault = e_wrong_sec > c_wrong_lim;
                    e_wrong_sec = 0;
                    e_sec_ticks = 0;
                end
            end
            REQ_UPDATE: estimate_update(t);
            default: ;
        endcase
        expected_results.push_back(estimator_result());
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        s_tvalid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_USER_DIR:   c_user_dir = val[0];
            REG_ANGLE_MODE: c_angle_mode = val[0];
            REG_OFFSET:     c_offset = val[23:0];
            REG_SCALE:      c_scale = val;
            REG_TIMEOUT:    c_timeout = val[15:0];
            REG_SPEED_MIN:  c_speed_min = val[30:0];
            REG_WRONG_LIM:  c_wrong_lim = val[15:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        hall_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[23:0], m_tdata[55:24], m_tdata[56], m_tdata[57], m_tdata[58],
                    m_tdata[59], m_tdata[75:60]};
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected");
                n_fail++;
            end else begin
                want = expected_results.pop_front();
                if (got.angle != want.angle) begin
                    $error("angle exp %0h got %0h", want.angle, got.angle); n_fail++;
                end
                if (got.speed != want.speed) begin
                    $error("speed exp %0h got %0h", want.speed, got.speed); n_fail++;
                end
                if (got.direction != want.direction) begin
                    $error("direction exp %0d got %0d", want.direction, got.direction);
                    n_fail++;
                end
                if (got.zero_speed != want.zero_speed) begin
                    $error("zero_speed exp %0d got %0d", want.zero_speed, got.zero_speed);
                    n_fail++;
                end
                if (got.above_min != want.above_min) begin
                    $error("above_min_speed exp %0d got %0d", want.above_min, got.above_min);
                    n_fail++;
                end
                if (got.fault != want.fault) begin
                    $error("sensor_fault exp %0d got %0d", want.fault, got.fault); n_fail++;
                end
                if (got.wrong_count != want.wrong_count) begin
                    $error("wrong_code_count exp %0d got %0d", want.wrong_count,
                           got.wrong_count);
                    n_fail++;
                end
            end
        end
    end

    // receiver ready, with random stalls and one long hold-off
    always @(negedge aclk) begin
        if (long_holdoff) begin
            m_tready <= 1'b0;
            repeat (400) @(negedge aclk);
            long_holdoff = 0;
        end else begin
            m_tready <= !(receiver_stall_pct > 0 && $urandom_range(99) < receiver_stall_pct);
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("hall_sensor_angle_speed_estimator_core: mismatch");
            $finish;
        end
    end

    // a rotor turning forward or in reverse: sectors in order, channels cycling
    int rot_step = 0;
    logic [31:0] rot_time = 0;
    task automatic rotor_edge(int period, bit rev);
        logic [2:0] seq [6] = '{3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};
        int k;
        rot_step = rev ? (rot_step + 5) % 6 : (rot_step + 1) % 6;
        rot_time += period;
        k = rev ? (6 - rot_step) % 3 : rot_step % 3;
        send_beat(REQ_EDGE, 2'(k), rot_time, seq[rot_step]);
    endtask

    task automatic test_directed();
        send_beat(REQ_UPDATE, 0, 0, 0);
        send_beat(REQ_EDGE, 0, 32'd100, 3'd0);
        send_beat(REQ_EDGE, 2'd3, 32'hFFFFFFFF, 3'd7);
        send_beat(REQ_EDGE, 1, 32'hFFFFFFF0, 3'd5);
        send_beat(REQ_EDGE, 2, 32'd50, 3'd2);
        send_beat(REQ_EDGE, 0, 32'd1000, 3'd7);
        send_beat(REQ_UPDATE, 0, 32'd1100, 0);
        send_beat(REQ_EDGE, 1, 32'hF0000000, 3'd4);
        send_beat(REQ_UPDATE, 0, 32'hF0001000, 0);
        send_beat(REQ_RESERVED, 3, 32'h12345678, 3'd6);
        send_beat(REQ_TICK, 0, 0, 0);
        send_beat(REQ_EDGE, 1, 32'hF0002000, 3'd6);
        send_beat(REQ_EDGE, 1, 32'hF0003000, 3'd1);
        send_beat(REQ_UPDATE, 0, 32'hF0003100, 0);
        drain();
    endtask

    task automatic test_rotation(int n, int max_period);
        int period;
        bit rev;
        rev = $urandom_range(1);
        period = $urandom_range(max_period, 1);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0: send_beat(REQ_TICK, 2'($urandom_range(3)), $urandom, 3'($urandom));
                1: send_beat(REQ_EDGE, 2'($urandom_range(3)), $urandom, 3'($urandom));
                2: rev = ~rev;
                3: period = $urandom_range(max_period, 1);
                4, 5, 6, 7, 8, 9: send_beat(REQ_UPDATE, 2'($urandom), rot_time +
                                   $urandom_range(period * 2), 3'($urandom));
                19: send_beat(2'($urandom_range(3)), 2'($urandom), $urandom, 3'($urandom));
                default: rotor_edge(period, rev);
            endcase
        end
    endtask

    task automatic test_timeout_and_fault();
        write_reg(REG_TIMEOUT, 3);
        write_reg(REG_WRONG_LIM, 2);
        repeat (6) rotor_edge(500, 0);
        repeat (5) send_beat(REQ_TICK, 0, 0, 0);
        send_beat(REQ_UPDATE, 0, rot_time, 0);
        repeat (2) rotor_edge(500, 0);
        send_beat(REQ_UPDATE, 0, rot_time + 10, 0);
        repeat (5) send_beat(REQ_EDGE, 2'($urandom_range(2)), $urandom, 3'($urandom));
        repeat (1001) send_beat(REQ_TICK, 0, 0, 0);
        send_beat(REQ_UPDATE, 0, rot_time, 0);
        drain();
    endtask

    task automatic test_settings(int phase);
        write_reg(REG_USER_DIR, $urandom_range(1));
        write_reg(REG_ANGLE_MODE, $urandom_range(1));
        write_reg(REG_OFFSET, phase == 0 ? 32'h00FFFFFF : $urandom);
        write_reg(REG_SCALE, phase == 0 ? 32'hFFFFFFFF : (phase == 1 ? 0 :
                  $urandom_range(100000, 10)));
        write_reg(REG_TIMEOUT, phase == 0 ? 16'hFFFF : $urandom_range(50, 0));
        write_reg(REG_SPEED_MIN, phase == 1 ? 32'h7FFFFFFF : $urandom_range(1 << 25));
        write_reg(REG_WRONG_LIM, phase == 0 ? 16'hFFFF : $urandom_range(5));
    endtask

    initial begin
        estimator_reset();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_timeout_and_fault();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
                default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
            endcase
            test_settings(ph);
            if (ph == 2) long_holdoff = 1;
            test_rotation(127, ph < 4 ? 3000 : 200000000);
            drain();
        end

        if (n_fail == 0) $display("hall_sensor_angle_speed_estimator_core: match");
        else $display("hall_sensor_angle_speed_estimator_core: mismatch");
        $finish;
    end
endmodule
